[rtl/pm_pkg.sv]
// pm_pkg: shared widths, defaults and the command/status structs of the
// polynomial multiplier. No dependencies.
package pm_pkg;

	localparam int MAX_TERMS_DEF = 32;
	localparam int COEFF_IN_W    = 16;
	localparam int PROD_W        = 2 * COEFF_IN_W;
	localparam int COEFF_OUT_W   = 40;
	localparam int POWER_W       = 6;
	localparam int IN_DATA_W     = 16;
	localparam int OUT_DATA_W    = 48;

	// controller to datapath
	typedef struct packed {
		logic load;        // input beat accepted
		logic start_coeff; // set up the index range of the next coefficient
		logic issue;       // read one a/b pair and advance
		logic emit;        // move the accumulator into the output register
		logic finish;      // empty both operands and the drop flag
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic a_empty;
		logic last_pair;
		logic last_coeff;
		logic acc_done;
		logic out_free;
	} sts_t;

endpackage

[rtl/pm_ram.sv]
// pm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/pm_ctrl.sv]
// pm_ctrl: sequencer of the polynomial multiplier: loading, per-coefficient
// issue of a/b pairs, and result emission. Depends on pm_pkg.
module pm_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_mode,
	input  logic         in_last,
	output logic         in_ready,
	input  pm_pkg::sts_t sts,
	output pm_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       can_emit;

	assign in_ready = (state_q == ST_LOAD);
	assign can_emit = (sts.acc_done || sts.a_empty) && sts.out_free;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.load = in_valid;
				if (in_valid && in_mode && in_last) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.start_coeff = 1'b1;
				state_d = sts.a_empty ? ST_WAIT : ST_ISSUE;
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (sts.last_pair) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (can_emit) begin
					cmd.emit = 1'b1;
					if (sts.last_coeff) begin
						cmd.finish = 1'b1;
						state_d = ST_LOAD;
					end else begin
						state_d = ST_START;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/pm_datapath.sv]
// pm_datapath: operand stores, counters, a/b index generation, multiply-
// accumulate pipeline and output register. Depends on pm_pkg and pm_ram.
module pm_datapath #(
	parameter int MAX_TERMS = pm_pkg::MAX_TERMS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pm_pkg::cmd_t                     cmd,
	output pm_pkg::sts_t                     sts,
	input  logic                             in_mode,
	input  logic [pm_pkg::COEFF_IN_W-1:0]    in_coeff,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pm_pkg::COEFF_OUT_W-1:0]   out_coeff,
	output logic [pm_pkg::POWER_W-1:0]       out_power,
	output logic                             out_last,
	output logic                             out_overflow
);

	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int PW = pm_pkg::POWER_W;

	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic          drop_q;
	logic [PW-1:0] k_q, i_q;
	logic [PW-1:0] na, nb, lo, hi, j, total_m1;
	logic          a_full, b_full;
	logic          wr_a, wr_b;

	logic [pm_pkg::COEFF_IN_W-1:0] a_rd, b_rd;
	logic                          valid_s1, last_s1;
	logic                          valid_s2, last_s2;
	logic signed [pm_pkg::PROD_W-1:0]      prod_s2;
	logic signed [pm_pkg::COEFF_OUT_W-1:0] acc_q;
	logic                                  done_q;

	assign na       = PW'(cnt_a_q);
	assign nb       = PW'(cnt_b_q);
	assign a_full   = (cnt_a_q == CW'(MAX_TERMS));
	assign b_full   = (cnt_b_q == CW'(MAX_TERMS));
	assign wr_a     = cmd.load && !in_mode && !a_full;
	assign wr_b     = cmd.load && in_mode && !b_full;
	// valid pairs of power k: max(0, k-nb+1) <= i <= min(k, na-1)
	assign lo       = (k_q >= nb) ? k_q - nb + 1'b1 : '0;
	assign hi       = (k_q < na) ? k_q : na - 1'b1;
	assign j        = k_q - i_q;
	assign total_m1 = na + nb - PW'(2);

	assign sts.a_empty    = (cnt_a_q == '0);
	assign sts.last_pair  = (i_q == hi);
	assign sts.last_coeff = sts.a_empty || (k_q == total_m1);
	assign sts.acc_done   = done_q;
	assign sts.out_free   = !out_valid || out_ready;

	pm_ram #(.WIDTH(pm_pkg::COEFF_IN_W), .DEPTH(MAX_TERMS)) u_ram_a (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (cnt_a_q[AW-1:0]),
		.wr_data (in_coeff),
		.rd_en   (cmd.issue),
		.rd_addr (i_q[AW-1:0]),
		.rd_data (a_rd)
	);

	pm_ram #(.WIDTH(pm_pkg::COEFF_IN_W), .DEPTH(MAX_TERMS)) u_ram_b (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (cnt_b_q[AW-1:0]),
		.wr_data (in_coeff),
		.rd_en   (cmd.issue),
		.rd_addr (j[AW-1:0]),
		.rd_data (b_rd)
	);

	// operand counters and index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			drop_q  <= 1'b0;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			if (wr_a) begin
				cnt_a_q <= cnt_a_q + 1'b1;
			end
			if (wr_b) begin
				cnt_b_q <= cnt_b_q + 1'b1;
			end
			if (cmd.load && ((!in_mode && a_full) || (in_mode && b_full))) begin
				drop_q <= 1'b1;
			end
			if (cmd.start_coeff) begin
				i_q <= lo;
			end else if (cmd.issue) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.finish) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				drop_q  <= 1'b0;
				k_q     <= '0;
			end else if (cmd.emit) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// read, multiply, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			last_s1  <= cmd.issue && sts.last_pair;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			if (cmd.start_coeff) begin
				done_q <= 1'b0;
			end else if (valid_s2 && last_s2) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= $signed(a_rd) * $signed(b_rd);
		end
		if (cmd.start_coeff) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + pm_pkg::COEFF_OUT_W'(prod_s2);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_coeff    <= acc_q;
			out_power    <= k_q;
			out_last     <= sts.last_coeff;
			out_overflow <= drop_q;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result loaded over an unaccepted beat");

	a_issue_a_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (PW'(i_q) < na))
		else $error("operand a index beyond its count");

	a_issue_b_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (j < nb))
		else $error("operand b index beyond its count");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!valid_s1 && !valid_s2))
		else $error("input beat taken while the mac pipeline is busy");

endmodule

[rtl/polynomial_multiply.sv]
// polynomial_multiply: top level of the coefficient-convolution multiplier.
// Depends on pm_pkg, pm_ctrl, pm_datapath (and pm_ram below it).
//
// Send the coefficients of operand A with tuser 0, then those of operand B
// with tuser 1, lowest power first, one beat per cycle; tlast on a B beat
// starts the product (tlast on an A beat has no effect). Up to MAX_TERMS
// coefficients per operand are kept, the rest are dropped and flagged in
// the result tuser. The block then returns lenA+lenB-1 product
// coefficients, lowest power first, with tlast on the highest one, or a
// single zero coefficient if A was empty; input is not taken until the last
// result has been loaded into the output register. One multiply-accumulate
// runs per cycle through a read, multiply, accumulate pipeline while the pairs
// of one coefficient are issued; the next one waits for a free output register.
module polynomial_multiply #(
	parameter int MAX_TERMS = pm_pkg::MAX_TERMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pm_pkg::IN_DATA_W-1:0]  s_tdata,  // [15:0] coeff_in
	input  logic                          s_tuser,  // [0] mode
	input  logic                          s_tlast,  // last_in
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pm_pkg::OUT_DATA_W-1:0] m_tdata,  // [39:0] coeff_out, [45:40] power
	output logic                          m_tuser,  // [0] overflow
	output logic                          m_tlast   // last_out
);

	pm_pkg::cmd_t cmd;
	pm_pkg::sts_t sts;

	logic [pm_pkg::COEFF_OUT_W-1:0] out_coeff;
	logic [pm_pkg::POWER_W-1:0]     out_power;

	pm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pm_datapath #(.MAX_TERMS(MAX_TERMS)) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_mode      (s_tuser),
		.in_coeff     (s_tdata[pm_pkg::COEFF_IN_W-1:0]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_coeff    (out_coeff),
		.out_power    (out_power),
		.out_last     (m_tlast),
		.out_overflow (m_tuser)
	);

	assign m_tdata = {2'b00, out_power, out_coeff};

endmodule
